// ===== rtl/plane_inlier_classifier_assert.svh =====
// Assertion macros used by the plane classifier RTL.
// Define ASSERT_OFF to compile them out.
`ifndef PLANE_INLIER_CLASSIFIER_ASSERT_SVH
`define PLANE_INLIER_CLASSIFIER_ASSERT_SVH

`ifndef ASSERT_OFF

// Property that must hold on every clock outside reset.
`define PIC_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Condition in this cycle implies the consequent in the next.
`define PIC_ASSERT_NEXT(label, clk, rst_n, cond, conseq, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (conseq)) \
    else $error(msg);

`else

`define PIC_ASSERT(label, clk, rst_n, prop, msg)
`define PIC_ASSERT_NEXT(label, clk, rst_n, cond, conseq, msg)

`endif

`endif

// ===== rtl/pic_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package pic_pkg;

  localparam int COLOR_W   = 8;
  localparam int CFG_W     = 16;
  localparam int MIN_W     = 20;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DAT_W = 32;
  localparam int IDX_OUT_W = 19;
  localparam int CNT_OUT_W = 20;
  localparam int MAG_LO_W  = 32;
  localparam int RHS_W     = 64;
  localparam int Q14_SHIFT = 14;

  localparam logic [COLOR_W-1:0] COLOR_FULL = 8'd255;
  localparam logic [COLOR_W-1:0] COLOR_NONE = 8'd0;

  // register reset values
  localparam logic signed [CFG_W-1:0] NORMAL_A_RST   = 16'sd0;
  localparam logic signed [CFG_W-1:0] NORMAL_B_RST   = -16'sd16384;
  localparam logic signed [CFG_W-1:0] NORMAL_C_RST   = 16'sd0;
  localparam logic signed [CFG_W-1:0] OFFSET_RST     = 16'sd500;
  localparam logic        [CFG_W-1:0] THRESHOLD_RST  = 16'd30;
  localparam logic        [MIN_W-1:0] MIN_INLIER_RST = 20'd2000;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_NORMAL_A    = 3'd0,
    CFG_NORMAL_B    = 3'd1,
    CFG_NORMAL_C    = 3'd2,
    CFG_OFFSET      = 3'd3,
    CFG_THRESHOLD   = 3'd4,
    CFG_MIN_INLIERS = 3'd5
  } cfg_reg_t;

  // payload that rides along the pipeline untouched
  typedef struct packed {
    logic [COLOR_W-1:0] red;
    logic [COLOR_W-1:0] green;
    logic [COLOR_W-1:0] blue;
    logic               last;
  } side_t;

  // dot product stage -> square/compare stage
  typedef struct packed {
    logic                vld;
    logic                big;     // |s| >= 2^32, square cannot be below rhs
    logic [MAG_LO_W-1:0] mag_lo;
    side_t               side;
  } dot_out_t;

  // square/compare stage -> tally stage
  typedef struct packed {
    logic  vld;
    logic  ground;
    side_t side;
  } test_out_t;

endpackage

`default_nettype wire

// ===== rtl/pic_dot.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Stages 1-3: products, plane sum, magnitude split.
module pic_dot #(
  parameter int COORD_BITS = 16
) (
  input  wire                                  clk,
  input  wire                                  rst_n,
  input  wire                                  in_valid,
  output logic                                 in_ready,
  input  wire  logic signed [COORD_BITS-1:0]   pos_x,
  input  wire  logic signed [COORD_BITS-1:0]   pos_y,
  input  wire  logic signed [COORD_BITS-1:0]   pos_z,
  input  wire  pic_pkg::side_t                 side_in,
  input  wire  logic signed [pic_pkg::CFG_W-1:0] normal_a,
  input  wire  logic signed [pic_pkg::CFG_W-1:0] normal_b,
  input  wire  logic signed [pic_pkg::CFG_W-1:0] normal_c,
  input  wire  logic signed [pic_pkg::CFG_W-1:0] plane_offset,
  output pic_pkg::dot_out_t                    dout,
  input  wire                                  dout_ready
);

  localparam int PROD_W = COORD_BITS + pic_pkg::CFG_W;
  localparam int S_W    = COORD_BITS + 21;

  logic                     v1_r, v2_r, v3_r;
  logic                     rdy1, rdy2, rdy3;
  logic signed [PROD_W-1:0] px_r, py_r, pz_r;
  logic signed [PROD_W-1:0] px_nxt, py_nxt, pz_nxt;
  logic signed [S_W-1:0]    s_r, s_nxt;
  logic [S_W-1:0]           s_bits, mag_nxt;
  logic                     big_r, big_nxt;
  logic [pic_pkg::MAG_LO_W-1:0] lo_r;
  pic_pkg::side_t           side1_r, side2_r, side3_r;

  assign rdy3     = !v3_r || dout_ready;
  assign rdy2     = !v2_r || rdy3;
  assign rdy1     = !v1_r || rdy2;
  assign in_ready = rdy1;

  assign px_nxt = PROD_W'(normal_a) * PROD_W'(pos_x);
  assign py_nxt = PROD_W'(normal_b) * PROD_W'(pos_y);
  assign pz_nxt = PROD_W'(normal_c) * PROD_W'(pos_z);

  assign s_nxt = S_W'(px_r) + S_W'(py_r) + S_W'(pz_r)
               + (S_W'(plane_offset) <<< pic_pkg::Q14_SHIFT);

  assign s_bits  = s_r;
  assign mag_nxt = s_bits[S_W-1] ? (~s_bits + S_W'(1)) : s_bits;
  assign big_nxt = |mag_nxt[S_W-1:pic_pkg::MAG_LO_W];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      if (rdy1) v1_r <= in_valid;
      if (rdy2) v2_r <= v1_r;
      if (rdy3) v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy1 && in_valid) begin
      px_r    <= px_nxt;
      py_r    <= py_nxt;
      pz_r    <= pz_nxt;
      side1_r <= side_in;
    end
    if (rdy2 && v1_r) begin
      s_r     <= s_nxt;
      side2_r <= side1_r;
    end
    if (rdy3 && v2_r) begin
      big_r   <= big_nxt;
      lo_r    <= mag_nxt[pic_pkg::MAG_LO_W-1:0];
      side3_r <= side2_r;
    end
  end

  always_comb begin
    dout.vld    = v3_r;
    dout.big    = big_r;
    dout.mag_lo = lo_r;
    dout.side   = side3_r;
  end

endmodule

`default_nettype wire

// ===== rtl/pic_test.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Stages 4-5: square of |s| and compare against t^2 * |n|^2.
// The right side comes from a free running three stage chain on config.
module pic_test (
  input  wire                                    clk,
  input  wire                                    rst_n,
  input  wire  logic signed [pic_pkg::CFG_W-1:0] normal_a,
  input  wire  logic signed [pic_pkg::CFG_W-1:0] normal_b,
  input  wire  logic signed [pic_pkg::CFG_W-1:0] normal_c,
  input  wire  logic [pic_pkg::CFG_W-1:0]        dist_threshold,
  input  wire  pic_pkg::dot_out_t                din,
  output logic                                   din_ready,
  output pic_pkg::test_out_t                     dout,
  input  wire                                    dout_ready
);

  localparam int SQ_W = 2 * pic_pkg::CFG_W;

  // config side
  logic signed [SQ_W-1:0]    sqa_nxt, sqb_nxt, sqc_nxt;
  logic [SQ_W-1:0]           sqa_r, sqb_r, sqc_r;
  logic [SQ_W-1:0]           tt_r, tt_nxt, tt2_r;
  logic [SQ_W-1:0]           nsq_r, nsq_nxt;
  logic [pic_pkg::RHS_W-1:0] rhs_r, rhs_nxt;

  // item side
  logic                      v4_r, v5_r;
  logic                      rdy4, rdy5;
  logic [pic_pkg::RHS_W-1:0] sq_r, sq_nxt;
  logic                      big4_r;
  logic                      ground_r, ground_nxt;
  pic_pkg::side_t            side4_r, side5_r;

  assign sqa_nxt = SQ_W'(normal_a) * SQ_W'(normal_a);
  assign sqb_nxt = SQ_W'(normal_b) * SQ_W'(normal_b);
  assign sqc_nxt = SQ_W'(normal_c) * SQ_W'(normal_c);
  assign tt_nxt  = SQ_W'(dist_threshold) * SQ_W'(dist_threshold);
  // each square <= 2^30, the sum fits 32 bits
  assign nsq_nxt = sqa_r + sqb_r + sqc_r;
  assign rhs_nxt = pic_pkg::RHS_W'(nsq_r) * pic_pkg::RHS_W'(tt2_r);

  always_ff @(posedge clk) begin
    sqa_r <= sqa_nxt;
    sqb_r <= sqb_nxt;
    sqc_r <= sqc_nxt;
    tt_r  <= tt_nxt;
    nsq_r <= nsq_nxt;
    tt2_r <= tt_r;
    rhs_r <= rhs_nxt;
  end

  assign rdy5      = !v5_r || dout_ready;
  assign rdy4      = !v4_r || rdy5;
  assign din_ready = rdy4;

  assign sq_nxt     = pic_pkg::RHS_W'(din.mag_lo) * pic_pkg::RHS_W'(din.mag_lo);
  assign ground_nxt = !big4_r && (sq_r < rhs_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v4_r <= 1'b0;
      v5_r <= 1'b0;
    end else begin
      if (rdy4) v4_r <= din.vld;
      if (rdy5) v5_r <= v4_r;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy4 && din.vld) begin
      sq_r    <= sq_nxt;
      big4_r  <= din.big;
      side4_r <= din.side;
    end
    if (rdy5 && v4_r) begin
      ground_r <= ground_nxt;
      side5_r  <= side4_r;
    end
  end

  always_comb begin
    dout.vld    = v5_r;
    dout.ground = ground_r;
    dout.side   = side5_r;
  end

endmodule

`default_nettype wire

// ===== rtl/pic_tally.sv =====
`timescale 1ns / 1ps
`default_nettype none
`include "plane_inlier_classifier_assert.svh"

// Stage 6: frame counters, recolor, output register.
module pic_tally #(
  parameter int MAX_POINTS = 524288
) (
  input  wire                                  clk,
  input  wire                                  rst_n,
  input  wire  pic_pkg::test_out_t             din,
  output logic                                 din_ready,
  input  wire  logic [pic_pkg::MIN_W-1:0]      min_inliers,
  output logic                                 out_valid,
  input  wire                                  out_stall,
  output logic [pic_pkg::IDX_OUT_W-1:0]        point_index,
  output logic                                 is_ground,
  output logic [pic_pkg::COLOR_W-1:0]          red_out,
  output logic [pic_pkg::COLOR_W-1:0]          green_out,
  output logic [pic_pkg::COLOR_W-1:0]          blue_out,
  output logic                                 frame_last,
  output logic [pic_pkg::CNT_OUT_W-1:0]        ground_count,
  output logic                                 plane_found
);

  localparam int IDX_W = $clog2(MAX_POINTS);
  localparam int CNT_W = $clog2(MAX_POINTS + 1);
  localparam int CMP_W = (CNT_W > pic_pkg::MIN_W) ? CNT_W : pic_pkg::MIN_W;

  logic [IDX_W-1:0] idx_r, idx_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt, cnt_sum;
  logic             acc;
  logic             found_nxt;

  logic                            out_valid_r;
  logic [pic_pkg::IDX_OUT_W-1:0]   point_index_r;
  logic                            ground_r;
  logic [pic_pkg::COLOR_W-1:0]     red_r, green_r, blue_r;
  logic                            last_r;
  logic [pic_pkg::CNT_OUT_W-1:0]   count_r;
  logic                            found_r;

  assign din_ready = !out_valid_r || !out_stall;
  assign acc       = din.vld && din_ready;

  // saturating inlier count including this point
  assign cnt_sum   = (din.ground && (cnt_r < CNT_W'(MAX_POINTS))) ? cnt_r + CNT_W'(1) : cnt_r;
  assign found_nxt = din.side.last && (CMP_W'(cnt_sum) >= CMP_W'(min_inliers));

  always_comb begin
    if (din.side.last) begin
      idx_nxt = '0;
      cnt_nxt = '0;
    end else begin
      idx_nxt = (idx_r == IDX_W'(MAX_POINTS - 1)) ? '0 : idx_r + IDX_W'(1);
      cnt_nxt = cnt_sum;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r       <= '0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (din_ready) out_valid_r <= din.vld;
      if (acc) begin
        idx_r <= idx_nxt;
        cnt_r <= cnt_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      point_index_r <= pic_pkg::IDX_OUT_W'(idx_r);
      ground_r      <= din.ground;
      red_r         <= din.ground ? pic_pkg::COLOR_FULL : din.side.red;
      green_r       <= din.ground ? pic_pkg::COLOR_NONE : din.side.green;
      blue_r        <= din.ground ? pic_pkg::COLOR_NONE : din.side.blue;
      last_r        <= din.side.last;
      count_r       <= pic_pkg::CNT_OUT_W'(cnt_sum);
      found_r       <= found_nxt;
    end
  end

  assign out_valid    = out_valid_r;
  assign point_index  = point_index_r;
  assign is_ground    = ground_r;
  assign red_out      = red_r;
  assign green_out    = green_r;
  assign blue_out     = blue_r;
  assign frame_last   = last_r;
  assign ground_count = count_r;
  assign plane_found  = found_r;

  `PIC_ASSERT(a_found_only_on_last, clk, rst_n, out_valid_r |-> (!found_r || last_r), "plane_found outside frame end")
  `PIC_ASSERT_NEXT(a_last_clears, clk, rst_n, acc && din.side.last, (idx_r == '0) && (cnt_r == '0), "counters not cleared after frame end")
  `PIC_ASSERT_NEXT(a_ground_counts, clk, rst_n, acc && din.ground && !din.side.last && (cnt_r < CNT_W'(MAX_POINTS)), cnt_r == $past(cnt_r) + CNT_W'(1), "inlier not counted")

endmodule

`default_nettype wire

// ===== rtl/plane_inlier_classifier.sv =====
// Each accepted input beat gives one result beat on the output register.
// Throughput: one point per cycle; a stalled output backs up stage by stage, bubbles collapse.
// Config changes reach the compare stage through the registered a^2 / sum / t^2*|n|^2 chain.
// Reset (rst_n low, synchronous): valid bits and frame counters cleared, config registers
// return to their defaults; cfg writes are accepted every cycle outside reset.
`timescale 1ns / 1ps
`default_nettype none

// Pipeline:
//   pic_dot   S1 a*x, b*y, c*z    S2 s = sum + d<<14    S3 |s|, split at bit 32
//   pic_test  S4 |s|^2 (32x32)    S5 |s|^2 < t^2*|n|^2
//   pic_tally S6 index/inlier counters, recolor, output register
// The right side t^2*|n|^2 is below 2^64, so any |s| >= 2^32 is never an inlier;
// only the low 32 bits of |s| go through the multiplier.
module plane_inlier_classifier #(
  parameter int MAX_POINTS = 524288,
  parameter int COORD_BITS = 16
) (
  input  wire                                   clk,
  input  wire                                   rst_n,

  // input point beats
  input  wire                                   in_valid,
  output logic                                  in_stall,
  input  wire  logic signed [COORD_BITS-1:0]    in_pos_x,
  input  wire  logic signed [COORD_BITS-1:0]    in_pos_y,
  input  wire  logic signed [COORD_BITS-1:0]    in_pos_z,
  input  wire  logic [pic_pkg::COLOR_W-1:0]     in_red_in,
  input  wire  logic [pic_pkg::COLOR_W-1:0]     in_green_in,
  input  wire  logic [pic_pkg::COLOR_W-1:0]     in_blue_in,
  input  wire                                   in_frame_end,

  // result beats
  output logic                                  out_valid,
  input  wire                                   out_stall,
  output logic [pic_pkg::IDX_OUT_W-1:0]         out_point_index,
  output logic                                  out_is_ground,
  output logic [pic_pkg::COLOR_W-1:0]           out_red_out,
  output logic [pic_pkg::COLOR_W-1:0]           out_green_out,
  output logic [pic_pkg::COLOR_W-1:0]           out_blue_out,
  output logic                                  out_frame_last,
  output logic [pic_pkg::CNT_OUT_W-1:0]         out_ground_count,
  output logic                                  out_plane_found,

  // register writes
  input  wire                                   cfg_valid,
  output logic                                  cfg_ready,
  input  wire  logic [pic_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire  logic [pic_pkg::CFG_DAT_W-1:0]   cfg_data
);

  logic signed [pic_pkg::CFG_W-1:0] normal_a_r, normal_b_r, normal_c_r, offset_r;
  logic [pic_pkg::CFG_W-1:0]        threshold_r;
  logic [pic_pkg::MIN_W-1:0]        min_inliers_r;

  logic                in_ready;
  pic_pkg::side_t      side_in;
  pic_pkg::dot_out_t   dot_out;
  logic                dot_ready;
  pic_pkg::test_out_t  test_out;
  logic                test_ready;

  // config port never back-pressures
  assign cfg_ready = 1'b1;

  // registers keep the low bits of the write data; unknown indexes are dropped
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      normal_a_r    <= pic_pkg::NORMAL_A_RST;
      normal_b_r    <= pic_pkg::NORMAL_B_RST;
      normal_c_r    <= pic_pkg::NORMAL_C_RST;
      offset_r      <= pic_pkg::OFFSET_RST;
      threshold_r   <= pic_pkg::THRESHOLD_RST;
      min_inliers_r <= pic_pkg::MIN_INLIER_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (pic_pkg::cfg_reg_t'(cfg_index))
        pic_pkg::CFG_NORMAL_A:    normal_a_r    <= cfg_data[pic_pkg::CFG_W-1:0];
        pic_pkg::CFG_NORMAL_B:    normal_b_r    <= cfg_data[pic_pkg::CFG_W-1:0];
        pic_pkg::CFG_NORMAL_C:    normal_c_r    <= cfg_data[pic_pkg::CFG_W-1:0];
        pic_pkg::CFG_OFFSET:      offset_r      <= cfg_data[pic_pkg::CFG_W-1:0];
        pic_pkg::CFG_THRESHOLD:   threshold_r   <= cfg_data[pic_pkg::CFG_W-1:0];
        pic_pkg::CFG_MIN_INLIERS: min_inliers_r <= cfg_data[pic_pkg::MIN_W-1:0];
        default: ;
      endcase
    end
  end

  assign in_stall = !in_ready;

  always_comb begin
    side_in.red   = in_red_in;
    side_in.green = in_green_in;
    side_in.blue  = in_blue_in;
    side_in.last  = in_frame_end;
  end

  pic_dot #(
    .COORD_BITS (COORD_BITS)
  ) u_dot (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .pos_x        (in_pos_x),
    .pos_y        (in_pos_y),
    .pos_z        (in_pos_z),
    .side_in      (side_in),
    .normal_a     (normal_a_r),
    .normal_b     (normal_b_r),
    .normal_c     (normal_c_r),
    .plane_offset (offset_r),
    .dout         (dot_out),
    .dout_ready   (dot_ready)
  );

  pic_test u_test (
    .clk            (clk),
    .rst_n          (rst_n),
    .normal_a       (normal_a_r),
    .normal_b       (normal_b_r),
    .normal_c       (normal_c_r),
    .dist_threshold (threshold_r),
    .din            (dot_out),
    .din_ready      (dot_ready),
    .dout           (test_out),
    .dout_ready     (test_ready)
  );

  pic_tally #(
    .MAX_POINTS (MAX_POINTS)
  ) u_tally (
    .clk          (clk),
    .rst_n        (rst_n),
    .din          (test_out),
    .din_ready    (test_ready),
    .min_inliers  (min_inliers_r),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .point_index  (out_point_index),
    .is_ground    (out_is_ground),
    .red_out      (out_red_out),
    .green_out    (out_green_out),
    .blue_out     (out_blue_out),
    .frame_last   (out_frame_last),
    .ground_count (out_ground_count),
    .plane_found  (out_plane_found)
  );

endmodule

`default_nettype wire
